[hdl/tlvf_pkg.sv]
// shared types and constants of the tlv tag finder
package tlvf_pkg;

  // parse phases of the front end
  typedef enum logic [2:0] {
    PH_TAG1  = 3'd0,
    PH_TAG2  = 3'd1,
    PH_LEN1  = 3'd2,
    PH_LENX  = 3'd3,
    PH_VALUE = 3'd4,
    PH_DONE  = 3'd5
  } tlvf_phase_t;

  // search status codes as seen on the result channel
  typedef enum logic [1:0] {
    ST_NOT_FOUND = 2'd0,
    ST_FOUND     = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_TRUNCATED = 2'd3
  } tlvf_status_t;

  // low five bits all set mark a two-byte tag
  localparam logic [4:0] TWO_BYTE_TAG_MARK = 5'h1f;

  // queue between parser and emitter
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // work for the back end caused by one input byte
  typedef struct packed {
    logic         has_value;
    logic [7:0]   value_byte;
    logic [15:0]  value_length;
    logic         value_last;
    logic         has_status;
    tlvf_status_t status;
    logic [15:0]  status_length;
  } tlvf_entry_t;

endpackage

[hdl/tlvf_ifs.sv]
// channel interfaces of the tlv tag finder

// input byte stream
interface tlvf_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// result items
interface tlvf_result_if;
  logic        valid;
  logic        ready;
  logic        is_value;
  logic [7:0]  value_byte;
  logic [15:0] value_length;
  logic [1:0]  search_status;
  logic        last_of_run;

  modport source (output valid, output is_value, output value_byte, output value_length,
                  output search_status, output last_of_run, input ready);
  modport sink   (input valid, input is_value, input value_byte, input value_length,
                  input search_status, input last_of_run, output ready);
  modport monitor (input valid, input ready, input is_value, input value_byte,
                   input value_length, input search_status, input last_of_run);
endinterface

// configuration write channel for the wanted tag
interface tlvf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] wanted_tag;

  modport source (output valid, output wanted_tag, input ready);
  modport sink   (input valid, input wanted_tag, output ready);
endinterface

[hdl/tlvf_parser.sv]
// front end: splits the byte stream into tlv fields and queues the work per byte
module tlvf_parser
  import tlvf_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = 2
) (
  input  logic          clk,
  input  logic          rst,
  tlvf_stream_if.sink   stream,
  tlvf_cfg_if.sink      cfg,
  output logic          push_valid,
  input  logic          push_ready,
  output tlvf_entry_t   push_entry
);

  localparam int LCW = $clog2(MAX_LENGTH_BYTES + 1);

  logic [15:0]  wanted_tag;
  tlvf_phase_t  phase, phase_next;
  logic [15:0]  tag_so_far, tag_so_far_next;
  logic [LCW-1:0] len_left, len_left_next;
  logic [15:0]  declared_length, declared_length_next;
  logic [15:0]  value_left, value_left_next;
  logic         matching, matching_next;
  tlvf_status_t result, result_next;

  logic         accept;
  logic         len_done;
  logic [15:0]  len_val;
  logic [15:0]  tag_full;
  tlvf_entry_t  entry;

  assign cfg.ready    = 1'b1;
  assign stream.ready = push_ready;
  assign accept       = stream.valid && push_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_tag <= '0;
    end else if (cfg.valid) begin
      wanted_tag <= cfg.wanted_tag;
    end
  end

  // parse step for one accepted byte
  always_comb begin
    phase_next           = phase;
    tag_so_far_next      = tag_so_far;
    len_left_next        = len_left;
    declared_length_next = declared_length;
    value_left_next      = value_left;
    matching_next        = matching;
    result_next          = result;
    len_done             = 1'b0;
    len_val              = '0;
    tag_full             = {tag_so_far[15:8], stream.data_byte};
    entry                = '0;

    if (accept) begin
      unique case (phase)
        PH_TAG1: begin
          if (stream.data_byte[4:0] == TWO_BYTE_TAG_MARK) begin
            tag_so_far_next = {stream.data_byte, 8'h00};
            phase_next      = PH_TAG2;
          end else begin
            tag_so_far_next = {8'h00, stream.data_byte};
            matching_next   = ({8'h00, stream.data_byte} == wanted_tag);
            phase_next      = PH_LEN1;
          end
        end
        PH_TAG2: begin
          tag_so_far_next = tag_full;
          matching_next   = (tag_full == wanted_tag);
          phase_next      = PH_LEN1;
        end
        PH_LEN1: begin
          declared_length_next = '0;
          if (stream.data_byte[7]) begin
            if (stream.data_byte[6:0] > 7'(MAX_LENGTH_BYTES)) begin
              result_next = ST_MALFORMED;
              phase_next  = PH_DONE;
            end else if (stream.data_byte[6:0] == 7'd0) begin
              len_done = 1'b1;
            end else begin
              len_left_next = stream.data_byte[LCW-1:0];
              phase_next    = PH_LENX;
            end
          end else begin
            declared_length_next = {8'h00, stream.data_byte};
            len_done             = 1'b1;
            len_val              = {8'h00, stream.data_byte};
          end
        end
        PH_LENX: begin
          declared_length_next = {declared_length[7:0], stream.data_byte};
          len_left_next        = len_left - LCW'(1);
          if (len_left == LCW'(1)) begin
            len_done = 1'b1;
            len_val  = {declared_length[7:0], stream.data_byte};
          end
        end
        PH_VALUE: begin
          value_left_next = value_left - 16'd1;
          if (matching) begin
            entry.has_value    = 1'b1;
            entry.value_byte   = stream.data_byte;
            entry.value_length = declared_length;
            entry.value_last   = (value_left == 16'd1);
          end
          if (value_left == 16'd1) begin
            if (matching) begin
              result_next = ST_FOUND;
              phase_next  = PH_DONE;
            end else begin
              phase_next = PH_TAG1;
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
          phase_next = PH_TAG1;
        end
      endcase

      // length field finished: go to the value or close the object
      if (len_done) begin
        if (len_val == 16'd0) begin
          if (matching_next) begin
            result_next = ST_FOUND;
            phase_next  = PH_DONE;
          end else begin
            phase_next = PH_TAG1;
          end
        end else begin
          value_left_next = len_val;
          phase_next      = PH_VALUE;
        end
      end

      // end of buffer: status item and fresh parse state
      if (stream.end_of_buffer) begin
        entry.has_status = 1'b1;
        entry.status     = result_next;
        if (result_next == ST_FOUND) begin
          entry.status_length = declared_length_next;
        end else if (result_next == ST_NOT_FOUND && phase_next != PH_TAG1) begin
          entry.status = ST_TRUNCATED;
        end
        phase_next           = PH_TAG1;
        tag_so_far_next      = '0;
        len_left_next        = '0;
        declared_length_next = '0;
        value_left_next      = '0;
        matching_next        = 1'b0;
        result_next          = ST_NOT_FOUND;
      end
    end
  end

  assign push_valid = accept && (entry.has_value || entry.has_status);
  assign push_entry = entry;

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_TAG1;
      tag_so_far      <= '0;
      len_left        <= '0;
      declared_length <= '0;
      value_left      <= '0;
      matching        <= 1'b0;
      result          <= ST_NOT_FOUND;
    end else begin
      phase           <= phase_next;
      tag_so_far      <= tag_so_far_next;
      len_left        <= len_left_next;
      declared_length <= declared_length_next;
      value_left      <= value_left_next;
      matching        <= matching_next;
      result          <= result_next;
    end
  end

endmodule

[hdl/tlvf_queue.sv]
// short fifo of work entries between parser and emitter
module tlvf_queue
  import tlvf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  tlvf_entry_t push_entry,
  output logic        pop_valid,
  input  logic        pop_ready,
  output tlvf_entry_t pop_entry
);

  tlvf_entry_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/tlvf_emitter.sv]
// back end: turns queued entries into value and status beats
module tlvf_emitter
  import tlvf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  tlvf_entry_t   pop_entry,
  tlvf_result_if.source result
);

  tlvf_entry_t cur, cur_next;
  logic        cur_valid, cur_valid_next;
  logic        slot_free;
  logic        emit;
  logic        remaining;

  assign slot_free = !result.valid || result.ready;
  assign emit      = slot_free && cur_valid;

  // what is left of the current entry after this cycle
  always_comb begin
    if (emit) begin
      remaining = cur.has_value && cur.has_status;
    end else begin
      remaining = cur_valid;
    end
    pop_ready = !remaining;
    if (remaining) begin
      cur_valid_next = 1'b1;
      cur_next       = cur;
      if (emit) begin
        cur_next.has_value = 1'b0;
      end
    end else begin
      cur_valid_next = pop_valid;
      cur_next       = pop_entry;
    end
  end

  // current entry
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else begin
      cur_valid <= cur_valid_next;
    end
    cur <= cur_next;
  end

  // output register, value beat ahead of status beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (slot_free) begin
      result.valid <= emit;
    end
    if (emit) begin
      if (cur.has_value) begin
        result.is_value      <= 1'b1;
        result.value_byte    <= cur.value_byte;
        result.value_length  <= cur.value_length;
        result.search_status <= ST_NOT_FOUND;
        result.last_of_run   <= cur.value_last;
      end else begin
        result.is_value      <= 1'b0;
        result.value_byte    <= '0;
        result.value_length  <= cur.status_length;
        result.search_status <= cur.status;
        result.last_of_run   <= 1'b1;
      end
    end
  end

endmodule

[hdl/tlv_tag_finder.sv]
// top level of the tlv tag finder
// Searches a byte stream of EMV-style TLV objects for the first object whose tag
// equals the configured wanted_tag and returns that object's value bytes, then one
// status beat on the byte marked end_of_buffer. The parser takes one byte per clock
// unless the queue is full; a byte costs one output beat when it carries a value
// byte or ends the buffer, and two when it does both, so the emitter's single output
// register sets the sustained rate at one beat per cycle while result.ready holds.
// Data passes the four-entry queue, the emitter's entry register and output register.
// Write wanted_tag only while no buffer is in flight.
module tlv_tag_finder
  import tlvf_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = 2
) (
  input  logic          clk,
  input  logic          rst,
  tlvf_stream_if.sink   stream,
  tlvf_cfg_if.sink      cfg,
  tlvf_result_if.source result
);

  logic        push_valid;
  logic        push_ready;
  tlvf_entry_t push_entry;
  logic        pop_valid;
  logic        pop_ready;
  tlvf_entry_t pop_entry;

  // front end
  tlvf_parser #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // decoupling queue
  tlvf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // back end
  tlvf_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .result    (result)
  );

endmodule

[hdl/tlvf_checker.sv]
// port-level checks of the tlv tag finder result channel
module tlvf_checker
  import tlvf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        is_value,
  input logic [7:0]  value_byte,
  input logic [15:0] value_length,
  input logic [1:0]  search_status,
  input logic        last_of_run
);

  // a stalled beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("result beat dropped while stalled");

  // a status beat always closes a run
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    valid && !is_value |-> last_of_run && value_byte == 8'h00)
    else $error("status beat not marked last or carries a byte");

  // a value beat carries no status and a nonzero length
  a_value_fields: assert property (@(posedge clk) disable iff (rst)
    valid && is_value |->
      search_status == ST_NOT_FOUND && value_length != 16'd0)
    else $error("value beat with status or zero length");

  // only a found status reports a length
  a_status_length: assert property (@(posedge clk) disable iff (rst)
    valid && !is_value && search_status != ST_FOUND |->
      value_length == 16'd0)
    else $error("length reported without a match");

endmodule

bind tlv_tag_finder tlvf_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (result.valid),
  .ready         (result.ready),
  .is_value      (result.is_value),
  .value_byte    (result.value_byte),
  .value_length  (result.value_length),
  .search_status (result.search_status),
  .last_of_run   (result.last_of_run)
);

[tb/tb.sv]
// testbench for the tlv tag finder: directed buffers, then random tlv buffers, checked by a predictor
`timescale 1ns / 1ps

module tb;
  import tlvf_pkg::*;

  localparam int MAX_LEN_BYTES = 2;

  // one result beat as seen on the result channel
  typedef struct packed {
    logic         is_value;
    logic [7:0]   value_byte;
    logic [15:0]  value_length;
    tlvf_status_t status;
    logic         last;
  } finder_beat_t;

  // one row of the directed table; typed rows carry their status beat
  typedef struct packed {
    logic [7:0]   data_byte;
    logic         eob;
    logic         typed;
    tlvf_status_t status;
    logic [15:0]  vlen;
  } dir_row_t;

  logic clk;
  logic rst;

  tlvf_stream_if stream ();
  tlvf_cfg_if    cfg ();
  tlvf_result_if result ();

  tlv_tag_finder #(
    .MAX_LENGTH_BYTES(MAX_LEN_BYTES)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .stream(stream),
    .cfg   (cfg),
    .result(result)
  );

  // clock, 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // search state mirrored from the block
  logic [15:0]  wanted_q;
  tlvf_phase_t  parse_ph;
  logic [15:0]  tag_acc;
  logic [2:0]   lenb_left;
  logic [15:0]  decl_len;
  logic [15:0]  val_left;
  logic         match_on;
  tlvf_status_t srch;

  finder_beat_t expected_beats[$];

  int errors = 0;
  int bytes_sent;
  int buffers_sent;
  int beats_seen = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int idle_pct;
  int stall_left = 0;

  // directed buffers, wanted tag 005a
  dir_row_t directed_rows [28] = '{
    // first byte after reset ends the buffer inside an object
    '{8'h00, 1'b1, 1'b1, ST_TRUNCATED, 16'd0},
    // match with two value bytes, end on the last one
    '{8'h5a, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h02, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h11, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'hff, 1'b1, 1'b0, ST_NOT_FOUND, 16'd0},
    // two-byte tag skipped, zero-length match, trailing byte ignored
    '{8'h9f, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h02, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h01, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h00, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h5a, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h00, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h33, 1'b1, 1'b1, ST_FOUND, 16'd0},
    // too many length bytes, rest ignored
    '{8'h5a, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h83, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h12, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h34, 1'b1, 1'b1, ST_MALFORMED, 16'd0},
    // zero count length on a miss, then a two-byte length on the match
    '{8'h01, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h80, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h5a, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h82, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h00, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h01, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'hee, 1'b1, 1'b0, ST_NOT_FOUND, 16'd0},
    // clean end on an object boundary, no match
    '{8'h01, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h00, 1'b1, 1'b1, ST_NOT_FOUND, 16'd0},
    // match cut short after one value byte
    '{8'h5a, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'h03, 1'b0, 1'b0, ST_NOT_FOUND, 16'd0},
    '{8'haa, 1'b1, 1'b0, ST_NOT_FOUND, 16'd0}
  };

  // back to the start of a buffer
  task automatic clear_search();
    parse_ph  = PH_TAG1;
    tag_acc   = '0;
    lenb_left = '0;
    decl_len  = '0;
    val_left  = '0;
    match_on  = 1'b0;
    srch      = ST_NOT_FOUND;
  endtask

  task automatic close_tag();
    match_on = (tag_acc == wanted_q);
    parse_ph = PH_LEN1;
  endtask

  task automatic close_length();
    if (decl_len == 16'd0) begin
      if (match_on) begin
        srch     = ST_FOUND;
        parse_ph = PH_DONE;
      end else begin
        parse_ph = PH_TAG1;
      end
    end else begin
      val_left = decl_len;
      parse_ph = PH_VALUE;
    end
  endtask

  // advance the search by one accepted byte and queue the beats it causes
  task automatic predict_tlv_byte(input logic [7:0] b, input logic eob);
    finder_beat_t beat;
    logic [6:0]   cnt;
    cnt = b[6:0];
    case (parse_ph)
      PH_TAG1: begin
        if (b[4:0] == TWO_BYTE_TAG_MARK) begin
          tag_acc  = {b, 8'h00};
          parse_ph = PH_TAG2;
        end else begin
          tag_acc = {8'h00, b};
          close_tag();
        end
      end
      PH_TAG2: begin
        tag_acc = tag_acc | {8'h00, b};
        close_tag();
      end
      PH_LEN1: begin
        decl_len = '0;
        if (b[7]) begin
          if (int'(cnt) > MAX_LEN_BYTES) begin
            srch     = ST_MALFORMED;
            parse_ph = PH_DONE;
          end else if (cnt == 7'd0) begin
            close_length();
          end else begin
            lenb_left = cnt[2:0];
            parse_ph  = PH_LENX;
          end
        end else begin
          decl_len = {8'h00, b};
          close_length();
        end
      end
      PH_LENX: begin
        decl_len  = {decl_len[7:0], b};
        lenb_left = lenb_left - 3'd1;
        if (lenb_left == 3'd0) close_length();
      end
      PH_VALUE: begin
        val_left = val_left - 16'd1;
        if (match_on) begin
          beat.is_value     = 1'b1;
          beat.value_byte   = b;
          beat.value_length = decl_len;
          beat.status       = ST_NOT_FOUND;
          beat.last         = (val_left == 16'd0);
          expected_beats.push_back(beat);
        end
        if (val_left == 16'd0) begin
          if (match_on) begin
            srch     = ST_FOUND;
            parse_ph = PH_DONE;
          end else begin
            parse_ph = PH_TAG1;
          end
        end
      end
      default: ;
    endcase
    // status beat closes the buffer
    if (eob) begin
      beat.is_value     = 1'b0;
      beat.value_byte   = 8'h00;
      beat.value_length = 16'd0;
      beat.status       = srch;
      beat.last         = 1'b1;
      if (srch == ST_FOUND)
        beat.value_length = decl_len;
      else if (srch == ST_NOT_FOUND && parse_ph != PH_TAG1)
        beat.status = ST_TRUNCATED;
      expected_beats.push_back(beat);
      clear_search();
    end
  endtask

  // present one byte, sometimes after a random gap, and wait until it is accepted
  task automatic send_tlv_byte(input logic [7:0] b, input logic eob);
    int gap;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 5);
      repeat (gap) begin
        stream.valid <= 1'b0;
        @(posedge clk);
      end
    end
    stream.valid         <= 1'b1;
    stream.data_byte     <= b;
    stream.end_of_buffer <= eob;
    @(posedge clk);
    while (!stream.ready) @(posedge clk);
    predict_tlv_byte(b, eob);
    bytes_sent++;
    if (eob) buffers_sent++;
  endtask

  // drain: every expected beat in, then the pipeline latency
  task automatic wait_drained();
    stream.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_wanted_tag(input logic [15:0] tag);
    cfg.valid      <= 1'b1;
    cfg.wanted_tag <= tag;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    wanted_q = tag;
  endtask

  // random buffers of tlv objects for one wanted tag
  task automatic run_random_phase(input logic [15:0] tag, input int pct, input int target);
    logic [7:0]  buffer_bytes[$];
    logic [7:0]  t;
    logic [15:0] big;
    logic        one_ok;
    logic        two_ok;
    logic        ended;
    int          sent;
    int          nobj;
    int          form;
    int          vlen;
    int          cut;
    int          o;
    write_wanted_tag(tag);
    idle_pct = pct;
    one_ok = (tag[15:8] == 8'h00) && (tag[4:0] != TWO_BYTE_TAG_MARK);
    two_ok = (tag[12:8] == TWO_BYTE_TAG_MARK);
    sent = 0;
    while (sent < target) begin
      buffer_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
        // noise buffer
        repeat ($urandom_range(1, 12)) buffer_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        nobj  = $urandom_range(1, 4);
        ended = 1'b0;
        for (o = 0; o < nobj && !ended; o++) begin
          // tag field, often the wanted one
          if ((one_ok || two_ok) && $urandom_range(0, 2) == 0) begin
            if (two_ok) buffer_bytes.push_back(tag[15:8]);
            buffer_bytes.push_back(tag[7:0]);
          end else begin
            t = 8'($urandom_range(0, 255));
            buffer_bytes.push_back(t);
            if (t[4:0] == TWO_BYTE_TAG_MARK) buffer_bytes.push_back(8'($urandom_range(0, 255)));
          end
          // length field in one of its forms
          vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
          form = $urandom_range(0, 9);
          if (form == 9 && $urandom_range(0, 2) != 0) form = 0;
          case (form)
            5: begin
              buffer_bytes.push_back(8'h80);
              vlen = 0;
            end
            6: begin
              buffer_bytes.push_back(8'h81);
              buffer_bytes.push_back(vlen[7:0]);
            end
            7: begin
              buffer_bytes.push_back(8'h82);
              buffer_bytes.push_back(8'h00);
              buffer_bytes.push_back(vlen[7:0]);
            end
            8: begin
              // long declared length, buffer ends inside the value
              big = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
              if ($urandom_range(0, 1) == 0) begin
                buffer_bytes.push_back(8'h81);
                buffer_bytes.push_back(8'h80 | big[7:0]);
              end else begin
                buffer_bytes.push_back(8'h82);
                buffer_bytes.push_back(big[15:8]);
                buffer_bytes.push_back(big[7:0]);
              end
              vlen  = $urandom_range(0, 8);
              ended = 1'b1;
            end
            9: begin
              buffer_bytes.push_back(8'h80 | 8'($urandom_range(MAX_LEN_BYTES + 1, 127)));
              vlen = $urandom_range(0, 4);
            end
            default: buffer_bytes.push_back(vlen[7:0]);
          endcase
          repeat (vlen) buffer_bytes.push_back(8'($urandom_range(0, 255)));
        end
        // sometimes cut the buffer short
        if (buffer_bytes.size() > 1 && $urandom_range(0, 5) == 0) begin
          cut = $urandom_range(1, buffer_bytes.size() - 1);
          while (buffer_bytes.size() > cut) void'(buffer_bytes.pop_back());
        end
      end
      foreach (buffer_bytes[i])
        send_tlv_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
      sent += buffer_bytes.size();
    end
    wait_drained();
  endtask

  // result side stalls in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      result.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      result.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 4);
    end else begin
      result.ready <= 1'b1;
    end
  end

  // compare each result beat with the oldest expected one
  always @(posedge clk) begin
    finder_beat_t got;
    finder_beat_t want;
    if (!rst && result.valid && result.ready) begin
      beats_seen++;
      got.is_value     = result.is_value;
      got.value_byte   = result.value_byte;
      got.value_length = result.value_length;
      got.status       = tlvf_status_t'(result.search_status);
      got.last         = result.last_of_run;
      if (!got.is_value) status_seen[result.search_status]++;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat isv=%0b byte=%02h len=%04h st=%0d last=%0b", $realtime,
                 got.is_value, got.value_byte, got.value_length, got.status, got.last);
      end else begin
        want = expected_beats.pop_front();
        if (got.is_value !== want.is_value || got.value_byte !== want.value_byte ||
            got.value_length !== want.value_length || got.status !== want.status ||
            got.last !== want.last) begin
          errors++;
          $display("%0t: mismatch expected isv=%0b byte=%02h len=%04h st=%0d last=%0b", $realtime,
                   want.is_value, want.value_byte, want.value_length, want.status, want.last);
          $display("%0t:          actual   isv=%0b byte=%02h len=%04h st=%0d last=%0b", $realtime,
                   got.is_value, got.value_byte, got.value_length, got.status, got.last);
        end
      end
    end
  end

  // stimulus
  initial begin
    finder_beat_t typed_beat;
    logic [7:0]   b0;
    bytes_sent   = 0;
    buffers_sent = 0;
    idle_pct     = 0;
    wanted_q     = 16'h0000;
    clear_search();
    rst                  <= 1'b1;
    stream.valid         <= 1'b0;
    stream.data_byte     <= 8'h00;
    stream.end_of_buffer <= 1'b0;
    cfg.valid            <= 1'b0;
    cfg.wanted_tag       <= 16'h0000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    write_wanted_tag(16'h005a);
    idle_pct = 30;
    foreach (directed_rows[i]) begin
      send_tlv_byte(directed_rows[i].data_byte, directed_rows[i].eob);
      if (directed_rows[i].typed) begin
        typed_beat.is_value     = 1'b0;
        typed_beat.value_byte   = 8'h00;
        typed_beat.value_length = directed_rows[i].vlen;
        typed_beat.status       = directed_rows[i].status;
        typed_beat.last         = 1'b1;
        void'(expected_beats.pop_back());
        expected_beats.push_back(typed_beat);
      end
    end
    wait_drained();

    // random phases over several wanted tags, extremes first
    run_random_phase(16'h0000, 30, 85);
    run_random_phase(16'hffff, 30, 85);
    b0 = 8'($urandom_range(0, 255));
    if (b0[4:0] == TWO_BYTE_TAG_MARK) b0[0] = 1'b0;
    run_random_phase({8'h00, b0}, 0, 85);
    run_random_phase({8'($urandom_range(0, 255)) | 8'h1f, 8'($urandom_range(0, 255))}, 50, 85);
    run_random_phase(16'($urandom_range(0, 65535)), 20, 85);
    run_random_phase(16'h9f36, 0, 85);

    wait_drained();
    $display("ran %0d bytes in %0d buffers over 7 wanted tags, %0d result beats checked",
             bytes_sent, buffers_sent, beats_seen);
    $display("status beats: %0d not found, %0d found, %0d malformed, %0d truncated",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
